@@ hdl/lshm_pkg.sv @@
// Package with constants, types and helper functions of the latency statistics monitor.
package lshm_pkg;

   localparam int LatBits = 32;
   localparam int CntBits = 32;
   localparam int SumBits = 64;
   localparam int ValBits = 33;
   localparam int Buckets = 8;
   localparam int BktBits = 3;
   localparam int IdxBits = 4;
   localparam int NumStats = 13;

   localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};
   localparam logic [ValBits-1:0] ValMax = {ValBits{1'b1}};

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_PEEK   = 2'd1,
      KIND_TAKE   = 2'd2,
      KIND_RESET  = 2'd3
   } kind_type;

   typedef enum logic [IdxBits-1:0] {
      STAT_COUNT   = 4'd0,
      STAT_CAP_MIN = 4'd1,
      STAT_CAP_MAX = 4'd2,
      STAT_CAP_AVG = 4'd3,
      STAT_WR_MIN  = 4'd4,
      STAT_WR_MAX  = 4'd5,
      STAT_WR_AVG  = 4'd6,
      STAT_TOT_MIN = 4'd7,
      STAT_TOT_MAX = 4'd8,
      STAT_TOT_AVG = 4'd9,
      STAT_P50     = 4'd10,
      STAT_P95     = 4'd11,
      STAT_P99     = 4'd12
   } stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PCT,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             record;
      logic             clear;
      logic             div_start;
      logic             pct_start;
      logic             pct_step;
      logic             emit;
      logic [IdxBits-1:0] idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic pct_done;
      logic empty;
   } sts_type;

   function automatic logic [BktBits-1:0] bucket_of(input logic [LatBits-1:0] us);
      logic [BktBits-1:0] b;
      b = 3'd0;
      if (us >= 32'd100)    b = 3'd1;
      if (us >= 32'd500)    b = 3'd2;
      if (us >= 32'd1000)   b = 3'd3;
      if (us >= 32'd5000)   b = 3'd4;
      if (us >= 32'd10000)  b = 3'd5;
      if (us >= 32'd50000)  b = 3'd6;
      if (us >= 32'd100000) b = 3'd7;
      return b;
   endfunction

   function automatic logic [ValBits-1:0] bucket_mid(input logic [BktBits-1:0] b);
      logic [ValBits-1:0] m;
      case (b)
         3'd0:    m = 33'd50;
         3'd1:    m = 33'd300;
         3'd2:    m = 33'd750;
         3'd3:    m = 33'd3000;
         3'd4:    m = 33'd7500;
         3'd5:    m = 33'd30000;
         3'd6:    m = 33'd75000;
         default: m = 33'd200000;
      endcase
      return m;
   endfunction

endpackage

@@ hdl/lshm_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the 64-bit sum over the sample count.
module lshm_divider import lshm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SumBits-1:0] dividend,
   input  logic [CntBits-1:0] divisor,
   output logic               done,
   output logic [SumBits-1:0] quotient
);

   logic [SumBits-1:0] quo_ff, quo_in;
   logic [CntBits:0]   rem_ff, rem_in;
   logic [CntBits-1:0] dvs_ff, dvs_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntBits:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CntBits-1:0], quo_ff[SumBits-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift one dividend bit into the partial remainder and try a subtraction.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[SumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(SumBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/lshm_datapath.sv @@
// Datapath of the latency statistics monitor: window registers, averages and percentiles.
module lshm_datapath import lshm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [LatBits-1:0] cap,
   input  logic [LatBits-1:0] wr,
   output sts_type            sts,
   output logic [ValBits-1:0] value
);

   logic [CntBits-1:0] count_ff;
   logic [SumBits-1:0] sum_cap_ff, sum_wr_ff, sum_tot_ff;
   logic [LatBits-1:0] min_cap_ff, max_cap_ff, min_wr_ff, max_wr_ff;
   logic [LatBits:0]   min_tot_ff, max_tot_ff;
   logic [CntBits-1:0] bkt_ff [Buckets];

   logic [LatBits:0]   tot;
   logic [BktBits-1:0] bkt;
   logic [SumBits:0]   sc, sw, st;

   // Averages: three divisions run one after another on the shared divider.
   logic [1:0]         dsel_ff;
   logic [ValBits-1:0] avg_ff [3];
   logic               div_go_ff;
   logic               div_done;
   logic [SumBits-1:0] div_q, div_a;

   // Percentile walk: one bucket per cycle, all three targets in parallel.
   logic [CntBits+6:0] tgt_ff [3];
   logic [CntBits+3:0] acc_ff;
   logic [BktBits-1:0] pb_ff;
   logic               pwalk_ff;
   logic [2:0]         pfound_ff;
   logic [ValBits-1:0] pct_ff [3];
   logic [CntBits+3:0] acc_nx;
   logic [CntBits+10:0] acc_x100;
   logic [CntBits+6:0] prod [3];

   assign tot = {1'b0, cap} + {1'b0, wr};
   assign bkt = bucket_of(cap);
   assign sc  = {1'b0, sum_cap_ff} + {{(SumBits-LatBits+1){1'b0}}, cap};
   assign sw  = {1'b0, sum_wr_ff}  + {{(SumBits-LatBits+1){1'b0}}, wr};
   assign st  = {1'b0, sum_tot_ff} + {{(SumBits-LatBits){1'b0}}, tot};

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff   <= '0;
         sum_cap_ff <= '0;
         sum_wr_ff  <= '0;
         sum_tot_ff <= '0;
         min_cap_ff <= '1;
         max_cap_ff <= '0;
         min_wr_ff  <= '1;
         max_wr_ff  <= '0;
         min_tot_ff <= '1;
         max_tot_ff <= '0;
         for (int i = 0; i < Buckets; i++) bkt_ff[i] <= '0;
      end else if (cmd.record) begin
         if (count_ff != CntMax) count_ff <= count_ff + 1'b1;
         sum_cap_ff <= sc[SumBits] ? '1 : sc[SumBits-1:0];
         sum_wr_ff  <= sw[SumBits] ? '1 : sw[SumBits-1:0];
         sum_tot_ff <= st[SumBits] ? '1 : st[SumBits-1:0];
         if (cap < min_cap_ff) min_cap_ff <= cap;
         if (cap > max_cap_ff) max_cap_ff <= cap;
         if (wr < min_wr_ff)   min_wr_ff  <= wr;
         if (wr > max_wr_ff)   max_wr_ff  <= wr;
         if (tot < min_tot_ff) min_tot_ff <= tot;
         if (tot > max_tot_ff) max_tot_ff <= tot;
         if (bkt_ff[bkt] != CntMax) bkt_ff[bkt] <= bkt_ff[bkt] + 1'b1;
      end
   end

   always_comb begin
      case (dsel_ff)
         2'd0:    div_a = sum_cap_ff;
         2'd1:    div_a = sum_wr_ff;
         default: div_a = sum_tot_ff;
      endcase
   end

   lshm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_a),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dsel_ff   <= 2'd0;
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         if (cmd.div_start) begin
            dsel_ff   <= 2'd0;
            div_go_ff <= 1'b1;
         end else if (div_done) begin
            avg_ff[dsel_ff] <= (div_q > {{(SumBits-ValBits){1'b0}}, ValMax}) ?
                               ValMax : div_q[ValBits-1:0];
            if (dsel_ff != 2'd2) begin
               dsel_ff   <= dsel_ff + 2'd1;
               div_go_ff <= 1'b1;
            end else begin
               dsel_ff <= 2'd3;
            end
         end
      end
   end

   // Products of the count with each percentage, registered at the start of the walk.
   assign prod[0] = 39'(count_ff) * 39'd50;
   assign prod[1] = 39'(count_ff) * 39'd95;
   assign prod[2] = 39'(count_ff) * 39'd99;
   assign acc_nx  = acc_ff + 36'(bkt_ff[pb_ff]);
   // The running total reaches floor(count * p / 100) exactly when
   // 100 * total + 100 exceeds count * p, so no division is needed.
   assign acc_x100 = {1'b0, acc_nx, 6'd0} + {2'd0, acc_nx, 5'd0} + {5'd0, acc_nx, 2'd0} +
                     43'd100;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwalk_ff  <= 1'b0;
         pfound_ff <= '0;
         pb_ff     <= '0;
         acc_ff    <= '0;
      end else if (cmd.pct_start) begin
         for (int j = 0; j < 3; j++) tgt_ff[j] <= prod[j];
         pwalk_ff  <= 1'b0;
         pfound_ff <= '0;
         pb_ff     <= '0;
         acc_ff    <= '0;
      end else if (cmd.pct_step) begin
         if (!pwalk_ff) begin
            pwalk_ff <= 1'b1;
         end else begin
            for (int j = 0; j < 3; j++) begin
               if (!pfound_ff[j] &&
                   (acc_x100 > {4'd0, tgt_ff[j]} || pb_ff == BktBits'(Buckets - 1))) begin
                  pfound_ff[j] <= 1'b1;
                  pct_ff[j]    <= bucket_mid(pb_ff);
               end
            end
            acc_ff <= acc_nx;
            if (pb_ff != BktBits'(Buckets - 1)) pb_ff <= pb_ff + 1'b1;
         end
      end
   end

   assign sts.div_done = (dsel_ff == 2'd3) && !div_go_ff;
   assign sts.pct_done = &pfound_ff;
   assign sts.empty    = (count_ff == '0);

   always_comb begin
      value = '0;
      if (!sts.empty) begin
         case (stat_type'(cmd.idx))
            STAT_COUNT:   value = ValBits'(count_ff);
            STAT_CAP_MIN: value = ValBits'(min_cap_ff);
            STAT_CAP_MAX: value = ValBits'(max_cap_ff);
            STAT_CAP_AVG: value = avg_ff[0];
            STAT_WR_MIN:  value = ValBits'(min_wr_ff);
            STAT_WR_MAX:  value = ValBits'(max_wr_ff);
            STAT_WR_AVG:  value = avg_ff[1];
            STAT_TOT_MIN: value = min_tot_ff;
            STAT_TOT_MAX: value = max_tot_ff;
            STAT_TOT_AVG: value = avg_ff[2];
            STAT_P50:     value = pct_ff[0];
            STAT_P95:     value = pct_ff[1];
            STAT_P99:     value = pct_ff[2];
            default:      value = '0;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_cap_ff <= max_cap_ff && min_tot_ff <= max_tot_ff))
      else $error("minimum above maximum in a non-empty window");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0))
      else $error("window not empty after clear");
   a_no_record_while_div: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !cmd.record)
      else $error("record during average computation");
`endif

endmodule

@@ hdl/lshm_ctrl.sv @@
// Controller state machine of the latency statistics monitor.
module lshm_ctrl import lshm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  sts_type    sts,
   output logic       busy,
   output cmd_type    cmd,
   output logic       strobe,
   output logic       last
);

   state_type          state_ff, state_in;
   logic               take_ff, take_in;
   logic [IdxBits-1:0] idx_ff, idx_in;
   logic               go;

   assign go = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      take_in  = take_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go && (kind == KIND_PEEK || kind == KIND_TAKE)) begin
               take_in  = (kind == KIND_TAKE);
               idx_in   = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (sts.div_done) state_in = ST_PCT;
         ST_PCT:       if (sts.pct_done) state_in = ST_EMIT;
         ST_EMIT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IdxBits'(NumStats - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.idx       = idx_ff;
      cmd.record    = go && (kind == KIND_RECORD);
      cmd.div_start = (state_ff == ST_IDLE) && state_in == ST_DIV_START;
      cmd.pct_start = (state_ff == ST_DIV_START);
      cmd.pct_step  = (state_ff == ST_DIV_WAIT) || (state_ff == ST_PCT);
      cmd.emit      = (state_ff == ST_EMIT);
      cmd.clear     = (go && kind == KIND_RESET) ||
                      (state_ff == ST_EMIT && take_ff && idx_ff == IdxBits'(NumStats - 1));
      strobe        = cmd.emit;
      last          = cmd.emit && idx_ff == IdxBits'(NumStats - 1);
      busy          = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      take_ff <= take_in;
      idx_ff  <= idx_in;
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      last |=> !busy)
      else $error("run did not end after last statistic");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (strobe && !last) |=> (strobe && idx_ff == $past(idx_ff) + 1'b1))
      else $error("statistics not emitted in order");
   a_record_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.record |-> !busy)
      else $error("record accepted while busy");
`endif

endmodule

@@ hdl/latency_stats_histogram_monitor.sv @@
// Top level of the latency statistics monitor with capture-latency histogram.
// Usage: drive req_kind and the two latencies with start high; an item is
// transferred at a rising edge where start is high and busy is low.
// A record (kind 0) and a reset (kind 3) give no result;
// busy stays low, so records can be transferred in every cycle.
// A peek (kind 1) or take (kind 2) raises busy and produces a run of 13
// results on rsp_stat_index, rsp_stat_value and rsp_last, each marked by
// rsp_strobe for one cycle, in index order, with rsp_last on the final one.
// The averages come from one shared bit-serial divider doing 64 steps per
// average, three averages in sequence; the results follow once the averages
// and the percentile walk are done. Busy falls after the last result, so the
// next item can be transferred in the cycle after it.
// A take clears the window in the cycle of its last result.
// The receiver cannot stall: every result must be taken in its strobe cycle.
// Reset empties the window (minima to all ones) and returns the block to idle.
module latency_stats_histogram_monitor import lshm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [LatBits-1:0] req_capture_latency,
   input  logic [LatBits-1:0] req_write_latency,
   output logic               rsp_strobe,
   output logic [IdxBits-1:0] rsp_stat_index,
   output logic [ValBits-1:0] rsp_stat_value,
   output logic               rsp_last
);

   cmd_type cmd;
   sts_type sts;

   lshm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_kind),
      .sts    (sts),
      .busy   (busy),
      .cmd    (cmd),
      .strobe (rsp_strobe),
      .last   (rsp_last)
   );

   lshm_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cap   (req_capture_latency),
      .wr    (req_write_latency),
      .sts   (sts),
      .value (rsp_stat_value)
   );

   assign rsp_stat_index = cmd.idx;

endmodule
